### rtl/tick_rate_ema_meter_defines.svh
// Assertion macros for the tick rate meter.
// Needs clk and arst_n in the scope of every use.
`ifndef TICK_RATE_EMA_METER_DEFINES_SVH
`define TICK_RATE_EMA_METER_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define TREM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define TREM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/trem_pkg.sv
// Shared types and constants of the tick rate meter.
// No dependencies; every other file but the defines header imports it.
`timescale 1ns / 1ps

package trem_pkg;

	localparam int STAMP_BITS = 32;
	localparam int COUNT_BITS = 20;

	localparam int TSTAMP_W  = 32;
	localparam int ELAPSED_W = 32;
	localparam int TOTAL_W   = 48;
	localparam int WSUM_W    = 40;
	localparam int PERIOD_W  = 48;
	localparam int RATE_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int RATIO_W   = 17;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;

	localparam int TOT_ADD_W = (STAMP_BITS > TOTAL_W ? STAMP_BITS : TOTAL_W) + 1;
	localparam int WIN_ADD_W = (STAMP_BITS > WSUM_W ? STAMP_BITS : WSUM_W) + 1;

	// Serial divider: one quotient bit a cycle
	localparam int DIV_W      = PERIOD_W;
	localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
	localparam int MEAN_STEPS = PERIOD_W;
	localparam int RATE_STEPS = RATE_W;
	// Top bits of (window << FRAC_W) that seed the remainder of the mean division
	localparam int MEAN_HI_W  = WSUM_W + FRAC_W - PERIOD_W;

	// Serial blend: one bit of the weights a cycle
	localparam int MIX_STEPS  = RATIO_W;
	localparam int MIX_CNT_W  = $clog2(MIX_STEPS + 1);
	localparam int MIX_ACC_W  = PERIOD_W + 3;
	localparam int MIX_PROD_W = MIX_ACC_W + RATIO_W;

	localparam logic [RATIO_W-1:0]  RATIO_ONE  = RATIO_W'(1 << FRAC_W);
	localparam logic [FRAC_W-1:0]   ROUND_HALF = FRAC_W'(1 << (FRAC_W - 1));
	localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = '1;
	localparam logic [WSUM_W-1:0]   WSUM_MAX   = '1;
	localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;
	localparam logic [RATE_W-1:0]   RATE_MAX   = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	localparam logic [CFG_W-1:0]   EVAL_RESET  = 32'd300000;
	localparam logic [RATIO_W-1:0] RATIO_RESET = 17'd32768;
	localparam logic [CFG_W-1:0]   TPS_RESET   = 32'd1000000;

	localparam logic [CFG_IDX_W-1:0] CFG_EVAL_INTERVAL    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AGE_RATIO        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 2'd2;

	typedef enum logic [1:0] {
		REQ_START   = 2'd0,
		REQ_TICK    = 2'd1,
		REQ_RESTART = 2'd2,
		REQ_STOP    = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WIN,
		ST_MEAN,
		ST_MIX,
		ST_BLEND,
		ST_RATE0,
		ST_RATE,
		ST_EMIT
	} meter_state_t;

	typedef struct packed {
		req_type_t             req_type;
		logic [TSTAMP_W-1:0]   timestamp;
	} in_item_t;

	typedef struct packed {
		logic [ELAPSED_W-1:0]  elapsed_ticks;
		logic [TOTAL_W-1:0]    total_ticks;
		logic [PERIOD_W-1:0]   period_avg;
		logic [RATE_W-1:0]     calls_per_second;
		logic                  running;
	} out_item_t;

	typedef struct packed {
		logic                  start;
		logic [DIV_W-1:0]      rem_init;
		logic [DIV_W-1:0]      divisor;
		logic [DIV_W-1:0]      numer;
		logic [DIV_CNT_W-1:0]  steps;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [DIV_W-1:0]      quot;
	} div_rsp_t;

	typedef struct packed {
		logic                  start;
		logic [RATIO_W-1:0]    ratio;
		logic [PERIOD_W-1:0]   mean;
		logic [PERIOD_W-1:0]   avg;
	} mix_req_t;

	typedef struct packed {
		logic                  done;
		logic [PERIOD_W-1:0]   period;
	} mix_rsp_t;

endpackage

### rtl/trem_div.sv
// Restoring divider, one quotient bit per cycle, numerator bits shifted in MSB first.
// Depends on trem_pkg.
`timescale 1ns / 1ps

module trem_div import trem_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     dvsr_q;
	logic [DIV_W-1:0]     numer_q;
	logic [DIV_W-1:0]     quot_q;

	logic [DIV_W:0]       shifted_w;
	logic [DIV_W:0]       diff_w;
	logic                 fit_w;

	// Remainder stays below the divisor, so the difference fits back in DIV_W bits
	assign shifted_w = {rem_q, numer_q[DIV_W-1]};
	assign fit_w     = shifted_w >= {1'b0, dvsr_q};
	assign diff_w    = shifted_w - {1'b0, dvsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q   <= req.rem_init;
			dvsr_q  <= req.divisor;
			numer_q <= req.numer;
			quot_q  <= '0;
		end else if (busy_q) begin
			rem_q   <= fit_w ? diff_w[DIV_W-1:0] : shifted_w[DIV_W-1:0];
			numer_q <= {numer_q[DIV_W-2:0], 1'b0};
			quot_q  <= {quot_q[DIV_W-2:0], fit_w};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

### rtl/trem_mix.sv
// Serial blend of window mean and averaged period, one weight bit per cycle, rounded.
// Depends on trem_pkg.
`timescale 1ns / 1ps

module trem_mix import trem_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mix_req_t req,
	output mix_rsp_t rsp
);

	logic                  busy_q;
	logic                  done_q;
	logic [MIX_CNT_W-1:0]  cnt_q;
	logic [RATIO_W-1:0]    a_q;
	logic [RATIO_W-1:0]    b_q;
	logic [PERIOD_W-1:0]   mean_q;
	logic [PERIOD_W-1:0]   avg_q;
	logic [MIX_PROD_W-1:0] prod_q;

	logic [RATIO_W-1:0]    ratio_w;
	logic [MIX_ACC_W-1:0]  sum_w;

	// Weights above one act as one
	assign ratio_w = (req.ratio > RATIO_ONE) ? RATIO_ONE : req.ratio;

	// Add both partial products at the top, then shift the whole product right
	assign sum_w = prod_q[MIX_PROD_W-1:RATIO_W]
		+ (a_q[0] ? MIX_ACC_W'(mean_q) : MIX_ACC_W'(0))
		+ (b_q[0] ? MIX_ACC_W'(avg_q) : MIX_ACC_W'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= MIX_CNT_W'(MIX_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - MIX_CNT_W'(1);
				if (cnt_q == MIX_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q    <= ratio_w;
			b_q    <= RATIO_ONE - ratio_w;
			mean_q <= req.mean;
			avg_q  <= req.avg;
			// Seed the rounding half so it lands at weight one after all shifts
			prod_q <= {MIX_ACC_W'(ROUND_HALF), {RATIO_W{1'b0}}};
		end else if (busy_q) begin
			a_q    <= a_q >> 1;
			b_q    <= b_q >> 1;
			prod_q <= {1'b0, sum_w, prod_q[RATIO_W-1:1]};
		end
	end

	assign rsp.done   = done_q;
	assign rsp.period = prod_q[PERIOD_W+FRAC_W-1:FRAC_W];

endmodule

### rtl/tick_rate_ema_meter.sv
// Call-rate meter over a free-running timestamp, with an averaged period and rate.
// Depends on trem_pkg, trem_div, trem_mix and tick_rate_ema_meter_defines.svh.
`timescale 1ns / 1ps
`include "tick_rate_ema_meter_defines.svh"

// Each input item carries a request type (start, tick, restart averaging, stop)
// and a timestamp; each gives exactly one result item with the elapsed ticks, the
// saturating running total, the averaged period (Q32.16) and the averaged call rate
// (Q16.16). One item is in work at a time. Start, restart, stop and any tick that
// does not close a window pass from the accepting state straight to the state
// that loads the result register.
// A tick whose window sum reaches eval_interval runs the bit-serial units: the
// divider for the window mean, then the blend unit, then the divider again for
// the rate; seeding the average skips the blend, and a saturated or trivial
// quotient skips its division. The result waits in an output register, so the
// next item is taken while it is still pending; a result that finds the register
// still full holds the block in its last state until the register is taken.
// Configuration writes are taken in any cycle and belong in idle time; index 3
// is ignored. There is no clearing pass after reset.

module tick_rate_ema_meter import trem_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	meter_state_t state_q, state_d;

	// Configuration
	logic [CFG_W-1:0]      eval_q;
	logic [RATIO_W-1:0]    ratio_q;
	logic [CFG_W-1:0]      tps_q;

	// Architectural state
	logic [STAMP_BITS-1:0] last_stamp_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [WSUM_W-1:0]     window_q;
	logic [PERIOD_W-1:0]   avg_q;
	logic [RATE_W-1:0]     rate_q;
	logic [TOTAL_W-1:0]    total_q;
	logic                  run_q;

	// Per-item payload
	logic [ELAPSED_W-1:0]  elapsed_q;
	logic [PERIOD_W-1:0]   mean_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic [STAMP_BITS-1:0] stamp_w;
	logic [STAMP_BITS-1:0] elapsed_w;
	logic [TOT_ADD_W-1:0]  total_add_w;
	logic [TOTAL_W-1:0]    total_sat_w;
	logic [WIN_ADD_W-1:0]  window_add_w;
	logic [WSUM_W-1:0]     window_sat_w;
	logic [COUNT_BITS-1:0] count_inc_w;
	logic                  win_close_w;
	logic                  mean_sat_w;
	logic                  rate_div_w;
	logic                  in_take_w;
	logic                  out_load_w;

	div_req_t div_req;
	div_rsp_t div_rsp;
	mix_req_t mix_req;
	mix_rsp_t mix_rsp;

	trem_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	trem_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mix_req),
		.rsp    (mix_rsp)
	);

	// Elapsed time wraps at the timestamp width; totals saturate
	assign stamp_w      = STAMP_BITS'(in_data.timestamp);
	assign elapsed_w    = stamp_w - last_stamp_q;
	assign total_add_w  = TOT_ADD_W'(total_q) + TOT_ADD_W'(elapsed_w);
	assign total_sat_w  = (total_add_w > TOT_ADD_W'(TOTAL_MAX)) ?
		TOTAL_MAX : total_add_w[TOTAL_W-1:0];
	assign window_add_w = WIN_ADD_W'(window_q) + WIN_ADD_W'(elapsed_w);
	assign window_sat_w = (window_add_w > WIN_ADD_W'(WSUM_MAX)) ?
		WSUM_MAX : window_add_w[WSUM_W-1:0];
	assign count_inc_w  = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_BITS'(1);
	assign win_close_w  = window_sat_w >= WSUM_W'(eval_q);

	// Mean overflows 48 bits when the top of (window << 16) already reaches the count
	assign mean_sat_w = DIV_W'(window_q[WSUM_W-1 -: MEAN_HI_W]) >= DIV_W'(count_q);
	// Rate needs the divider only when the quotient fits in 32 bits
	assign rate_div_w = (tps_q != '0) && (avg_q != '0) && (DIV_W'(tps_q) < avg_q);

	assign in_take_w = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_take_w) begin
					if (in_data.req_type == REQ_TICK && win_close_w) state_d = ST_WIN;
					else state_d = ST_EMIT;
				end
			end
			ST_WIN:   state_d = mean_sat_w ? ST_MIX : ST_MEAN;
			ST_MEAN:  if (div_rsp.done) state_d = ST_MIX;
			ST_MIX:   state_d = (avg_q == '0) ? ST_RATE0 : ST_BLEND;
			ST_BLEND: if (mix_rsp.done) state_d = ST_RATE0;
			ST_RATE0: state_d = rate_div_w ? ST_RATE : ST_EMIT;
			ST_RATE:  if (div_rsp.done) state_d = ST_EMIT;
			ST_EMIT:  if (out_load_w) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Control outputs and unit requests
	always_comb begin
		in_ready   = 1'b0;
		out_load_w = 1'b0;
		div_req    = '0;
		mix_req    = '0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_WIN: begin
				div_req.start    = !mean_sat_w;
				div_req.rem_init = DIV_W'(window_q[WSUM_W-1 -: MEAN_HI_W]);
				div_req.divisor  = DIV_W'(count_q);
				div_req.numer    = {window_q[PERIOD_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
				div_req.steps    = DIV_CNT_W'(MEAN_STEPS);
			end
			ST_MIX: begin
				mix_req.start = avg_q != '0;
				mix_req.ratio = ratio_q;
				mix_req.mean  = mean_q;
				mix_req.avg   = avg_q;
			end
			ST_RATE0: begin
				div_req.start    = rate_div_w;
				div_req.rem_init = DIV_W'(tps_q);
				div_req.divisor  = avg_q;
				div_req.numer    = '0;
				div_req.steps    = DIV_CNT_W'(RATE_STEPS);
			end
			ST_EMIT: out_load_w = !out_valid_q || out_ready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Configuration and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eval_q       <= EVAL_RESET;
			ratio_q      <= RATIO_RESET;
			tps_q        <= TPS_RESET;
			last_stamp_q <= '0;
			count_q      <= '0;
			window_q     <= '0;
			avg_q        <= '0;
			rate_q       <= '0;
			total_q      <= '0;
			run_q        <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_EVAL_INTERVAL:    eval_q  <= cfg_data;
					CFG_AGE_RATIO:        ratio_q <= cfg_data[RATIO_W-1:0];
					CFG_TICKS_PER_SECOND: tps_q   <= cfg_data;
					default: begin
					end
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take_w) begin
						unique case (in_data.req_type)
							REQ_START: begin
								run_q        <= 1'b1;
								total_q      <= '0;
								last_stamp_q <= stamp_w;
							end
							REQ_TICK: begin
								total_q      <= total_sat_w;
								count_q      <= count_inc_w;
								window_q     <= window_sat_w;
								last_stamp_q <= stamp_w;
							end
							REQ_RESTART: begin
								total_q      <= total_sat_w;
								count_q      <= '0;
								window_q     <= '0;
								avg_q        <= '0;
								rate_q       <= '0;
								last_stamp_q <= stamp_w;
							end
							REQ_STOP: begin
								// Hold the last stamp
								run_q    <= 1'b0;
								total_q  <= total_sat_w;
								count_q  <= '0;
								window_q <= '0;
								avg_q    <= '0;
								rate_q   <= '0;
							end
						endcase
					end
				end
				ST_WIN: begin
					// The divider has taken its operands: drop the window now
					count_q  <= '0;
					window_q <= '0;
				end
				ST_MIX: if (avg_q == '0) avg_q <= mean_q;
				ST_BLEND: if (mix_rsp.done) avg_q <= mix_rsp.period;
				ST_RATE0: begin
					if (!rate_div_w) rate_q <= (tps_q == '0) ? '0 : RATE_MAX;
				end
				ST_RATE: if (div_rsp.done) rate_q <= div_rsp.quot[RATE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Per-item payload, no reset
	always_ff @(posedge clk) begin
		if (in_take_w) begin
			elapsed_q <= (in_data.req_type == REQ_START) ? '0 : ELAPSED_W'(elapsed_w);
		end
		if (state_q == ST_WIN && mean_sat_w) mean_q <= PERIOD_MAX;
		if (state_q == ST_MEAN && div_rsp.done) mean_q <= div_rsp.quot[PERIOD_W-1:0];
		if (out_load_w) begin
			out_q.elapsed_ticks    <= elapsed_q;
			out_q.total_ticks      <= total_q;
			out_q.period_avg       <= avg_q;
			out_q.calls_per_second <= rate_q;
			out_q.running          <= run_q;
		end
	end

	// Output register: hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load_w) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`TREM_ASSERT_NEXT(a_one_item, in_take_w, !in_ready, "item taken while another is in work")
	`TREM_ASSERT_NOW(a_div_owner, div_rsp.done, state_q == ST_MEAN || state_q == ST_RATE, "divider finished outside a division state")
	`TREM_ASSERT_NOW(a_mix_owner, mix_rsp.done, state_q == ST_BLEND, "blend finished outside the blend state")
	`TREM_ASSERT_NOW(a_out_source, $rose(out_valid), $past(state_q) == ST_EMIT, "result shown without a load")

endmodule

### tb/tb_tick_rate_ema_meter.sv
`timescale 1ns / 1ps
// Self-checking bench for tick_rate_ema_meter: request items in, result items out.
// Depends on trem_pkg and the tick_rate_ema_meter RTL; every result is checked
// against an in-bench copy of the period and rate averaging.

module tb_tick_rate_ema_meter;
	import trem_pkg::*;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_item_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	tick_rate_ema_meter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Register copies, as last written through the configuration channel
	logic [CFG_W-1:0]   win_limit  = EVAL_RESET;
	logic [RATIO_W-1:0] age_weight = RATIO_RESET;
	logic [CFG_W-1:0]   tick_rate  = TPS_RESET;

	// Meter state as the block should hold it after each accepted item
	logic [STAMP_BITS-1:0] prev_stamp = '0;
	logic [COUNT_BITS-1:0] sample_cnt = '0;
	logic [WSUM_W-1:0]     win_sum    = '0;
	logic [PERIOD_W-1:0]   period_q   = '0;
	logic [RATE_W-1:0]     rate_q     = '0;
	logic [TOTAL_W-1:0]    run_total  = '0;
	logic                  is_running = 1'b0;

	in_item_t  request_queue[$];
	out_item_t expected_reports[$];

	logic [TSTAMP_W-1:0] stamp_cursor = '0;
	logic no_idle    = 1'b0;
	int   fail_count = 0;
	int   send_hold  = 0;
	int   stall_left = 0;

	function automatic logic [63:0] clamp_add(logic [63:0] a, logic [63:0] b,
			logic [63:0] lim);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, lim}) ? lim : s[63:0];
	endfunction

	// Close the window: fold its mean period into the average (or seed it when
	// the average is zero), then rederive the call rate and empty the window.
	function automatic void close_window();
		logic [63:0] divisor;
		logic [63:0] mean;
		logic [63:0] weight;
		logic [63:0] quot;
		logic [65:0] mix;
		divisor = (sample_cnt == '0) ? 64'd1 : 64'(sample_cnt);
		mean = (64'(win_sum) << FRAC_W) / divisor;
		if (mean > 64'(PERIOD_MAX))
			mean = 64'(PERIOD_MAX);
		// ratios above one act as one
		weight = (age_weight > RATIO_ONE) ? 64'(RATIO_ONE) : 64'(age_weight);
		if (period_q == '0) begin
			period_q = mean[PERIOD_W-1:0];
		end else begin
			mix = 66'(weight) * 66'(mean) + 66'(64'(RATIO_ONE) - weight) * 66'(period_q)
				+ 66'(ROUND_HALF);
			period_q = mix[FRAC_W +: PERIOD_W];
		end
		if (tick_rate == '0) begin
			rate_q = '0;
		end else if (period_q == '0) begin
			rate_q = RATE_MAX;
		end else begin
			quot = {tick_rate, 32'b0} / 64'(period_q);
			rate_q = (quot > 64'(RATE_MAX)) ? RATE_MAX : quot[RATE_W-1:0];
		end
		sample_cnt = '0;
		win_sum    = '0;
	endfunction

	// Apply one request to the meter state and return the result it must give
	function automatic out_item_t advance_meter(in_item_t req);
		logic [ELAPSED_W-1:0] span;
		out_item_t rep;
		span = req.timestamp - prev_stamp;
		if (req.req_type != REQ_START)
			run_total = TOTAL_W'(clamp_add(64'(run_total), 64'(span), 64'(TOTAL_MAX)));
		case (req.req_type)
			REQ_START: begin
				is_running = 1'b1;
				run_total  = '0;
				prev_stamp = req.timestamp;
				span       = '0;
			end
			REQ_TICK: begin
				if (sample_cnt != COUNT_MAX)
					sample_cnt = sample_cnt + 1'b1;
				win_sum = WSUM_W'(clamp_add(64'(win_sum), 64'(span), 64'(WSUM_MAX)));
				if (64'(win_sum) >= 64'(win_limit))
					close_window();
				prev_stamp = req.timestamp;
			end
			default: begin
				// restart and stop both drop the window and the averages
				period_q   = '0;
				rate_q     = '0;
				sample_cnt = '0;
				win_sum    = '0;
				if (req.req_type == REQ_RESTART)
					prev_stamp = req.timestamp;
				else
					is_running = 1'b0;
			end
		endcase
		rep.elapsed_ticks    = span;
		rep.total_ticks      = run_total;
		rep.period_avg       = period_q;
		rep.calls_per_second = rate_q;
		rep.running          = is_running;
		return rep;
	endfunction

	// Mostly no pause, often a short one, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (no_idle)
			return 0;
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_report(out_item_t got);
		out_item_t want;
		if (expected_reports.size() == 0) begin
			$error("result item with nothing expected: %h", got);
			fail_count++;
		end else begin
			want = expected_reports.pop_front();
			compare_field("elapsed_ticks", want.elapsed_ticks, got.elapsed_ticks);
			compare_field("total_ticks", want.total_ticks, got.total_ticks);
			compare_field("period_avg", want.period_avg, got.period_avg);
			compare_field("calls_per_second", want.calls_per_second, got.calls_per_second);
			compare_field("running", want.running, got.running);
		end
	endtask

	// Request driver: on acceptance, predict; then hold a random gap or present
	// the next queued item. Valid only drops once the current item has gone.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			in_data   <= '0;
			send_hold = 0;
		end else begin
			if (in_valid && in_ready)
				expected_reports.push_back(advance_meter(in_data));
			if (!in_valid || in_ready) begin
				if (send_hold > 0) begin
					in_valid <= 1'b0;
					send_hold--;
				end else if (request_queue.size() > 0) begin
					in_valid  <= 1'b1;
					in_data   <= request_queue.pop_front();
					send_hold = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check each accepted item, then stall at random, both just
	// after a result and while the block is still at work.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				check_report(out_data);
				stall_left = pick_gap();
			end else if (stall_left == 0 && $urandom_range(0, 15) == 0) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Write one register and mirror it once the block has taken it
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_EVAL_INTERVAL:    win_limit  = value;
			CFG_AGE_RATIO:        age_weight = value[RATIO_W-1:0];
			CFG_TICKS_PER_SECOND: tick_rate  = value;
			default: ;
		endcase
	endtask

	// Hold until every queued item is sent and every expected result is back
	task automatic wait_idle();
		while (request_queue.size() != 0 || in_valid || expected_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic queue_req(req_type_t kind, logic [TSTAMP_W-1:0] ts);
		in_item_t it;
		it.req_type  = kind;
		it.timestamp = ts;
		request_queue.push_back(it);
		stamp_cursor = ts;
	endtask

	task automatic queue_tick(logic [TSTAMP_W-1:0] delta);
		queue_req(REQ_TICK, stamp_cursor + delta);
	endtask

	// Mostly ticks spaced against the current window length, so windows close
	// every few items and blends pile up; the rest are starts, restarts, stops
	// and wholly random items.
	task automatic random_phase(int count);
		logic [TSTAMP_W-1:0] span_max;
		int roll;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			span_max = (win_limit == '0) ? 32'd64 : (win_limit >> $urandom_range(0, 3));
			if (roll < 80) begin
				if ($urandom_range(0, 15) == 0)
					queue_tick($urandom);
				else
					queue_tick($urandom_range(0, span_max));
			end else if (roll < 86) begin
				queue_req(REQ_START, stamp_cursor + $urandom_range(0, span_max));
			end else if (roll < 92) begin
				queue_req(REQ_RESTART, stamp_cursor + $urandom_range(0, span_max));
			end else if (roll < 97) begin
				queue_req(REQ_STOP, stamp_cursor + $urandom_range(0, span_max));
			end else begin
				queue_req(req_type_t'($urandom_range(0, 3)), $urandom);
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset register values: idle tick, wrapped stamps, seeding, blending,
		// the largest elapsed time, restart, stop, tick while idle, start extremes
		queue_req(REQ_TICK, 32'h0000_0000);
		queue_req(REQ_START, 32'hFFFF_FFF0);
		queue_tick(32'h0000_0020);
		queue_tick(32'd299990);
		queue_tick(32'd100000);
		queue_tick(32'd100000);
		queue_tick(32'd100000);
		queue_tick(32'hFFFF_FFFF);
		queue_tick(32'h0000_0000);
		queue_req(REQ_RESTART, stamp_cursor + 32'd1000);
		queue_tick(32'd150000);
		queue_tick(32'd150000);
		queue_req(REQ_STOP, stamp_cursor + 32'd5);
		queue_tick(32'd400000);
		queue_req(REQ_START, 32'hFFFF_FFFF);
		queue_req(REQ_START, 32'h0000_0000);
		queue_tick(32'h8000_0000);
		wait_idle();

		// Zero window length closes a window on every tick. An empty window
		// seeds a zero period, so the rate saturates; a full-weight blend with a
		// zero mean drops the period back to zero and the next window reseeds.
		write_reg(CFG_EVAL_INTERVAL, 32'd0);
		write_reg(CFG_AGE_RATIO, 32'd65536);
		queue_tick(32'd0);
		queue_tick(32'd5);
		queue_tick(32'd0);
		queue_tick(32'd7);
		wait_idle();
		// ratio above one, then zero ticks per second, then the unused index
		write_reg(CFG_AGE_RATIO, 32'h0001_FFFF);
		queue_tick(32'd3);
		wait_idle();
		write_reg(CFG_TICKS_PER_SECOND, 32'd0);
		queue_tick(32'd9);
		queue_tick(32'd2);
		wait_idle();
		write_reg(2'd3, $urandom);
		queue_tick(32'd4);
		wait_idle();

		// Pile up the largest elapsed times back to back: stop keeps the last
		// stamp, so repeated stops one tick behind it each add the largest step.
		no_idle = 1'b1;
		write_reg(CFG_EVAL_INTERVAL, 32'hFFFF_FFFF);
		write_reg(CFG_TICKS_PER_SECOND, TPS_RESET);
		queue_req(REQ_START, 32'h1234_5678);
		repeat (24) queue_req(REQ_STOP, 32'h1234_5677);
		queue_req(REQ_TICK, 32'h1234_5677);
		queue_req(REQ_START, 32'h0000_0100);
		wait_idle();

		// Random phases, each under its own register setting; the first three
		// take the extremes. Between phases the sender holds until all is back.
		for (int p = 0; p < 10; p++) begin
			case (p)
				0: begin
					write_reg(CFG_EVAL_INTERVAL, 32'd1);
					write_reg(CFG_AGE_RATIO, 32'd0);
					write_reg(CFG_TICKS_PER_SECOND, 32'hFFFF_FFFF);
				end
				1: begin
					write_reg(CFG_EVAL_INTERVAL, 32'hFFFF_FFFF);
					write_reg(CFG_AGE_RATIO, 32'd65536);
					write_reg(CFG_TICKS_PER_SECOND, 32'd1);
				end
				2: begin
					write_reg(CFG_EVAL_INTERVAL, 32'd0);
					write_reg(CFG_AGE_RATIO, 32'h0001_FFFF);
					write_reg(CFG_TICKS_PER_SECOND, 32'd0);
				end
				default: begin
					write_reg(CFG_EVAL_INTERVAL, $urandom >> $urandom_range(0, 28));
					// junk above the ratio field must be dropped
					write_reg(CFG_AGE_RATIO, {15'($urandom),
						($urandom_range(0, 3) == 0) ? 17'($urandom)
						: 17'($urandom_range(0, 65536))});
					write_reg(CFG_TICKS_PER_SECOND, $urandom >> $urandom_range(0, 24));
				end
			endcase
			no_idle = ($urandom_range(0, 3) == 0);
			random_phase(110);
			wait_idle();
		end

		// Let any stray result show up before the verdict
		no_idle = 1'b0;
		repeat (200) @(posedge clk);
		if (fail_count == 0 && expected_reports.size() == 0)
			$display("tb_tick_rate_ema_meter OK");
		else
			$display("tb_tick_rate_ema_meter NOT OK");
		$finish;
	end

	// Watchdog: several times the slowest legal run
	initial begin
		#30_000_000;
		$display("tb_tick_rate_ema_meter NOT OK");
		$finish;
	end

endmodule
